// ===== rtl/uri_field_splitter_core_defines.svh =====
// Assertion macros shared by the URI field splitter RTL.
`ifndef URI_FIELD_SPLITTER_CORE_DEFINES_SVH
`define URI_FIELD_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define UFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uri field splitter check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define UFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uri field splitter check failed");

`endif

// ===== rtl/ufs_pkg.sv =====
// Shared types and constants of the URI field splitter.
`timescale 1ns / 1ps
`default_nettype none
package ufs_pkg;

	localparam int CHAR_W      = 8;
	localparam int PORT_W      = 16;
	localparam int MINLEN_W    = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int HOST_MAX     = 128;
	localparam int PATH_MAX_LEN = 256;

	localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST   = 9'd8;
	localparam logic [PORT_W-1:0]   DEFAULT_PORT_RST = 16'd80;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PORT = 2'd1;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_SHORT      = 3'd1;
	localparam status_t ST_BAD_CHAR   = 3'd2;
	localparam status_t ST_BAD_FORMAT = 3'd3;
	localparam status_t ST_RELATIVE   = 3'd4;

	typedef enum logic [2:0] {
		CL_HOST,
		CL_DIGIT,
		CL_COLON,
		CL_SLASH,
		CL_BLANK,
		CL_OTHER
	} char_class_t;

	typedef struct packed {
		logic        end_marker;
		char_class_t cls;
		logic [3:0]  digit;
	} ufs_word_t;

	function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
		char_class_t r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = CL_DIGIT;
		end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
				c == 8'h2E || c == 8'h2D || c == 8'h5F) begin
			r = CL_HOST;
		end else if (c == 8'h3A) begin
			r = CL_COLON;
		end else if (c == 8'h2F) begin
			r = CL_SLASH;
		end else if (c == 8'h20 || c == 8'h0A || c == 8'h0D) begin
			r = CL_BLANK;
		end else begin
			r = CL_OTHER;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ufs_if.sv =====
// Valid/ready channel interfaces of the URI field splitter.
`timescale 1ns / 1ps
`default_nettype none
interface ufs_char_if;
	import ufs_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              end_marker;
	modport source(output valid, output character, output end_marker, input ready);
	modport sink(input valid, input character, input end_marker, output ready);
endinterface

interface ufs_field_if;
	import ufs_pkg::*;
	logic              valid;
	logic              ready;
	status_t           status;
	logic              protocol_given;
	logic [3:0]        protocol_length;
	logic [7:0]        host_start;
	logic [6:0]        host_length;
	logic              port_given;
	logic [PORT_W-1:0] port_number;
	logic [7:0]        path_start;
	logic [7:0]        path_length;
	logic [7:0]        trimmed_length;
	modport source(output valid, output status, output protocol_given,
		output protocol_length, output host_start, output host_length,
		output port_given, output port_number, output path_start,
		output path_length, output trimmed_length, input ready);
	modport sink(input valid, input status, input protocol_given,
		input protocol_length, input host_start, input host_length,
		input port_given, input port_number, input path_start,
		input path_length, input trimmed_length, output ready);
endinterface

interface ufs_cfg_if;
	import ufs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ufs_front.sv =====
// Front end: takes character words and classifies them into one register stage.
`timescale 1ns / 1ps
`default_nettype none
module ufs_front (
	input  logic              clk,
	input  logic              arst_n,
	ufs_char_if.sink          chars,
	output ufs_pkg::ufs_word_t word,
	output logic              word_valid,
	input  logic              word_ready
);
	import ufs_pkg::*;

	logic      valid_s1;
	ufs_word_t word_s1;

	assign chars.ready = !valid_s1 || word_ready;
	assign word_valid  = valid_s1;
	assign word        = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			word_s1.end_marker <= chars.end_marker;
			word_s1.cls        <= classify(chars.character);
			word_s1.digit      <= chars.character[3:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ufs_queue.sv =====
// Short word queue between the classifier and the parser.
`timescale 1ns / 1ps
`default_nettype none
module ufs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  ufs_pkg::ufs_word_t push_word,
	input  logic              push_valid,
	output logic              push_ready,
	output ufs_pkg::ufs_word_t pop_word,
	output logic              pop_valid,
	input  logic              pop_ready
);
	import ufs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	ufs_word_t     mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          push;
	logic          pop;

	assign push_ready = count_q != (AW+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_word   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ufs_back.sv =====
// Back end: phase machine over classified words and the result register.
`timescale 1ns / 1ps
`default_nettype none
module ufs_back #(
	parameter int URI_MAX      = 256,
	parameter int PROTOCOL_MAX = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ufs_pkg::ufs_word_t             word,
	input  logic                          word_valid,
	output logic                          word_ready,
	input  logic [ufs_pkg::MINLEN_W-1:0]  min_length,
	input  logic [ufs_pkg::PORT_W-1:0]    default_port,
	ufs_field_if.source                   fields
);
	import ufs_pkg::*;

	localparam int OW  = $clog2(URI_MAX);
	localparam int PLW = $clog2(PROTOCOL_MAX);
	localparam int WW  = (OW > MINLEN_W) ? OW : MINLEN_W;
	localparam int PROTO_LIM = (PROTOCOL_MAX - 1 < 15) ? PROTOCOL_MAX - 1 : 15;
	localparam int HOST_LIM  = (HOST_MAX - 1 < 127) ? HOST_MAX - 1 : 127;
	localparam int PATH_LIM  = (PATH_MAX_LEN - 1 < 255) ? PATH_MAX_LEN - 1 : 255;
	localparam int BYTE_MAX  = 255;

	localparam logic [3:0] PH_LEAD   = 4'd0;
	localparam logic [3:0] PH_HOST0  = 4'd1;
	localparam logic [3:0] PH_COLON  = 4'd2;
	localparam logic [3:0] PH_CS1    = 4'd3;
	localparam logic [3:0] PH_HOST1  = 4'd4;
	localparam logic [3:0] PH_COLON2 = 4'd5;
	localparam logic [3:0] PH_PORT   = 4'd6;
	localparam logic [3:0] PH_PATH   = 4'd7;
	localparam logic [3:0] PH_ERR    = 4'd8;

	typedef struct packed {
		status_t           status;
		logic              protocol_given;
		logic [3:0]        protocol_length;
		logic [7:0]        host_start;
		logic [6:0]        host_length;
		logic              port_given;
		logic [PORT_W-1:0] port_number;
		logic [7:0]        path_start;
		logic [7:0]        path_length;
		logic [7:0]        trimmed_length;
	} result_t;

	function automatic logic [7:0] sat_byte(input logic [WW-1:0] v);
		return (v > WW'(BYTE_MAX)) ? 8'hFF : v[7:0];
	endfunction

	logic [3:0]     phase_q, phase_d;
	status_t        err_q, err_d;
	logic [OW-1:0]  fill_q, fill_d;
	logic [OW-1:0]  tlen_q, tlen_d;
	logic           pend_q, pend_d;
	logic [OW-1:0]  host_beg_q, host_beg_d;
	logic [OW-1:0]  host_end_q, host_end_d;
	logic [PLW-1:0] proto_len_q, proto_len_d;
	logic [PORT_W-1:0] port_q, port_d;
	logic [OW-1:0]  path_beg_q, path_beg_d;
	logic           proto_given_q, proto_given_d;
	logic           port_given_q, port_given_d;
	logic           path_given_q, path_given_d;

	logic           res_valid_q;
	result_t        res_q;
	result_t        res_c;

	logic           out_free;
	logic           load;
	logic           is_blank;
	logic           room;
	logic           step_en;
	char_class_t    cls_e;
	logic [OW-1:0]  pos;
	logic [PLW-1:0] proto_sat;
	logic [PORT_W+3:0] port_wide;
	logic [PORT_W-1:0] port_acc;
	logic           too_short;
	status_t        status_c;
	logic [OW-1:0]  host_last;
	logic [WW-1:0]  host_len_w;
	logic [WW-1:0]  path_len_w;

	assign out_free   = !res_valid_q || fields.ready;
	assign load       = word_valid && word.end_marker && out_free;
	assign word_ready = !word.end_marker || out_free;

	assign pos       = fill_q;
	assign is_blank  = word.cls == CL_BLANK;
	assign room      = fill_q != OW'(URI_MAX - 1);
	assign proto_sat = (WW'(pos) > WW'(PROTOCOL_MAX - 1)) ? PLW'(PROTOCOL_MAX - 1) : PLW'(pos);
	assign port_wide = ({4'b0, port_q} << 3) + ({4'b0, port_q} << 1)
		+ {{PORT_W{1'b0}}, word.digit};
	assign port_acc  = (|port_wide[PORT_W+3:PORT_W]) ? {PORT_W{1'b1}} : port_wide[PORT_W-1:0];

	always_comb begin
		phase_d       = phase_q;
		err_d         = err_q;
		fill_d        = fill_q;
		tlen_d        = tlen_q;
		pend_d        = pend_q;
		host_beg_d    = host_beg_q;
		host_end_d    = host_end_q;
		proto_len_d   = proto_len_q;
		port_d        = port_q;
		path_beg_d    = path_beg_q;
		proto_given_d = proto_given_q;
		port_given_d  = port_given_q;
		path_given_d  = path_given_q;
		step_en       = 1'b0;
		cls_e         = word.cls;

		if (word_valid && !word.end_marker) begin
			if (phase_q == PH_LEAD && is_blank) begin
				step_en = 1'b0;
			end else if (room) begin
				fill_d = fill_q + OW'(1);
				if (is_blank) begin
					pend_d = 1'b1;
				end else begin
					tlen_d  = fill_q + OW'(1);
					pend_d  = 1'b0;
					step_en = 1'b1;
					if (pend_q) begin
						cls_e = CL_BLANK;
					end
				end
			end else if (!is_blank) begin
				tlen_d  = fill_q;
				pend_d  = 1'b0;
				step_en = pend_q;
				cls_e   = CL_BLANK;
			end
		end

		if (step_en) begin
			case (phase_q)
				PH_LEAD, PH_HOST0: begin
					case (cls_e)
						CL_HOST, CL_DIGIT: phase_d = PH_HOST0;
						CL_COLON: begin
							phase_d     = PH_COLON;
							host_end_d  = pos;
							proto_len_d = proto_sat;
						end
						CL_SLASH: begin
							if (pos == '0) begin
								phase_d = PH_ERR;
								err_d   = ST_RELATIVE;
							end else begin
								phase_d      = PH_PATH;
								host_end_d   = pos;
								path_beg_d   = pos;
								path_given_d = 1'b1;
							end
						end
						default: begin
							phase_d = PH_ERR;
							err_d   = ST_BAD_CHAR;
						end
					endcase
				end
				PH_COLON: begin
					case (cls_e)
						CL_SLASH: phase_d = PH_CS1;
						CL_DIGIT: begin
							phase_d      = PH_PORT;
							port_d       = {{(PORT_W-4){1'b0}}, word.digit};
							port_given_d = 1'b1;
						end
						default: begin
							phase_d = PH_ERR;
							err_d   = ST_BAD_FORMAT;
						end
					endcase
				end
				PH_CS1: begin
					case (cls_e)
						CL_SLASH: begin
							phase_d       = PH_HOST1;
							host_beg_d    = pos + OW'(1);
							proto_given_d = 1'b1;
						end
						default: begin
							phase_d = PH_ERR;
							err_d   = ST_BAD_FORMAT;
						end
					endcase
				end
				PH_HOST1: begin
					case (cls_e)
						CL_HOST, CL_DIGIT: phase_d = PH_HOST1;
						CL_COLON: begin
							phase_d    = PH_COLON2;
							host_end_d = pos;
						end
						CL_SLASH: begin
							phase_d      = PH_PATH;
							host_end_d   = pos;
							path_beg_d   = pos;
							path_given_d = 1'b1;
						end
						default: begin
							phase_d = PH_ERR;
							err_d   = ST_BAD_FORMAT;
						end
					endcase
				end
				PH_COLON2: begin
					case (cls_e)
						CL_DIGIT: begin
							phase_d      = PH_PORT;
							port_d       = {{(PORT_W-4){1'b0}}, word.digit};
							port_given_d = 1'b1;
						end
						default: begin
							phase_d = PH_ERR;
							err_d   = ST_BAD_FORMAT;
						end
					endcase
				end
				PH_PORT: begin
					case (cls_e)
						CL_DIGIT: port_d = port_acc;
						CL_SLASH: begin
							phase_d      = PH_PATH;
							path_beg_d   = pos;
							path_given_d = 1'b1;
						end
						default: begin
							phase_d = PH_ERR;
							err_d   = ST_BAD_FORMAT;
						end
					endcase
				end
				default: phase_d = phase_q;
			endcase
		end

		if (load) begin
			phase_d       = PH_LEAD;
			err_d         = ST_OK;
			fill_d        = '0;
			tlen_d        = '0;
			pend_d        = 1'b0;
			host_beg_d    = '0;
			port_d        = '0;
			proto_given_d = 1'b0;
			port_given_d  = 1'b0;
			path_given_d  = 1'b0;
		end
	end

	assign too_short  = WW'(tlen_q) <= WW'(min_length);
	assign host_last  = (phase_q == PH_HOST0 || phase_q == PH_HOST1) ? tlen_q : host_end_q;
	assign host_len_w = WW'(host_last - host_beg_q);
	assign path_len_w = WW'(tlen_q - path_beg_q);

	always_comb begin
		case (phase_q)
			PH_ERR:                       status_c = err_q;
			PH_COLON, PH_CS1, PH_COLON2:  status_c = ST_BAD_FORMAT;
			PH_LEAD:                      status_c = ST_SHORT;
			default:                      status_c = ST_OK;
		endcase
		if (too_short) begin
			status_c = ST_SHORT;
		end

		res_c                 = '0;
		res_c.status          = status_c;
		res_c.trimmed_length  = sat_byte(WW'(tlen_q));
		if (status_c == ST_OK) begin
			res_c.protocol_given  = proto_given_q;
			if (proto_given_q) begin
				res_c.protocol_length = (WW'(proto_len_q) > WW'(PROTO_LIM)) ?
					4'(PROTO_LIM) : 4'(proto_len_q);
			end
			res_c.host_start  = sat_byte(WW'(host_beg_q));
			res_c.host_length = (host_len_w > WW'(HOST_LIM)) ? 7'(HOST_LIM) : host_len_w[6:0];
			res_c.port_given  = port_given_q;
			res_c.port_number = port_given_q ? port_q : default_port;
			if (path_given_q) begin
				res_c.path_start  = sat_byte(WW'(path_beg_q));
				res_c.path_length = (path_len_w > WW'(PATH_LIM)) ?
					8'(PATH_LIM) : path_len_w[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEAD;
			err_q         <= ST_OK;
			fill_q        <= '0;
			tlen_q        <= '0;
			pend_q        <= 1'b0;
			host_beg_q    <= '0;
			host_end_q    <= '0;
			proto_len_q   <= '0;
			port_q        <= '0;
			path_beg_q    <= '0;
			proto_given_q <= 1'b0;
			port_given_q  <= 1'b0;
			path_given_q  <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			err_q         <= err_d;
			fill_q        <= fill_d;
			tlen_q        <= tlen_d;
			pend_q        <= pend_d;
			host_beg_q    <= host_beg_d;
			host_end_q    <= host_end_d;
			proto_len_q   <= proto_len_d;
			port_q        <= port_d;
			path_beg_q    <= path_beg_d;
			proto_given_q <= proto_given_d;
			port_given_q  <= port_given_d;
			path_given_q  <= path_given_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (fields.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_c;
		end
	end

	assign fields.valid           = res_valid_q;
	assign fields.status          = res_q.status;
	assign fields.protocol_given  = res_q.protocol_given;
	assign fields.protocol_length = res_q.protocol_length;
	assign fields.host_start      = res_q.host_start;
	assign fields.host_length     = res_q.host_length;
	assign fields.port_given      = res_q.port_given;
	assign fields.port_number     = res_q.port_number;
	assign fields.path_start      = res_q.path_start;
	assign fields.path_length     = res_q.path_length;
	assign fields.trimmed_length  = res_q.trimmed_length;

endmodule
`default_nettype wire

// ===== rtl/uri_field_splitter_core.sv =====
// Top level of the URI field splitter: front, queue, back and register file.
//
// channel  direction  payload                                   handshake
// chars    in         character[7:0], end_marker                valid / ready
// fields   out        status .. trimmed_length, ten fields      valid / ready
// cfg      in         index[1:0], data[15:0]                    valid / ready, always ready
//
// One character word per cycle sustained while results are taken; the back end's phase
// machine takes one word per cycle; a result passes front register, queue, result register.
// arst_n clears the parse state and sets min_length to 8, default_port to 80.
// A four-word queue parts classifier and parser; an end word waits at its head while
// the result register is full, then the queue and front register fill and chars stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "uri_field_splitter_core_defines.svh"
module uri_field_splitter_core #(
	parameter int URI_MAX      = 256,
	parameter int PROTOCOL_MAX = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	ufs_char_if.sink     chars,
	ufs_field_if.source  fields,
	ufs_cfg_if.sink      cfg
);
	import ufs_pkg::*;

	ufs_word_t           s1_word;
	logic                s1_valid;
	logic                s1_ready;
	ufs_word_t           q_word;
	logic                q_valid;
	logic                q_ready;
	logic [MINLEN_W-1:0] min_length_q;
	logic [PORT_W-1:0]   default_port_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q   <= MIN_LENGTH_RST;
			default_port_q <= DEFAULT_PORT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MIN_LENGTH:   min_length_q   <= cfg.data[MINLEN_W-1:0];
				REG_DEFAULT_PORT: default_port_q <= cfg.data[PORT_W-1:0];
				default:          min_length_q   <= min_length_q;
			endcase
		end
	end

	ufs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.word       (s1_word),
		.word_valid (s1_valid),
		.word_ready (s1_ready)
	);

	ufs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_word  (s1_word),
		.push_valid (s1_valid),
		.push_ready (s1_ready),
		.pop_word   (q_word),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	ufs_back #(
		.URI_MAX      (URI_MAX),
		.PROTOCOL_MAX (PROTOCOL_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.word         (q_word),
		.word_valid   (q_valid),
		.word_ready   (q_ready),
		.min_length   (min_length_q),
		.default_port (default_port_q),
		.fields       (fields)
	);

	`UFS_ASSERT_NEXT(a_front_hold, s1_valid && !s1_ready, s1_valid && $stable(s1_word))
	`UFS_ASSERT_NOW(a_ok_nonempty, fields.valid && fields.status == ST_OK, fields.trimmed_length != 8'd0)
	`UFS_ASSERT_NOW(a_err_no_port, fields.valid && fields.status != ST_OK, fields.port_number == 16'd0 && !fields.port_given)
	`UFS_ASSERT_NOW(a_load_from_end, $rose(fields.valid), $past(q_valid && q_ready && q_word.end_marker))

endmodule
`default_nettype wire
